### rtl/integer_to_ascii_padded_macros.svh
// Assertion macros shared by the checker of the integer to ASCII block.
`ifndef INTEGER_TO_ASCII_PADDED_MACROS_SVH
`define INTEGER_TO_ASCII_PADDED_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ITOA_IMPLY(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("itoa check failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off during rst.
`define ITOA_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("itoa check failed: next-cycle implication");

`endif

### rtl/itoa_pkg.sv
// Types and constants of the integer to padded ASCII converter.
package itoa_pkg;

  typedef enum logic [1:0] {
    KIND_SDEC = 2'd0,
    KIND_UDEC = 2'd1,
    KIND_HEXL = 2'd2,
    KIND_HEXU = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] value;
    logic        wide;
    logic [5:0]  pad_width;
    logic        zero_pad;
  } item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } result_t;

  localparam int NumDigits = 20;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChSpace = 8'h20;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = ChZero + {4'b0, d};
    end else if (upper) begin
      c = 8'h41 + {4'b0, d - 4'd10};
    end else begin
      c = 8'h61 + {4'b0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

### rtl/integer_to_ascii_padded.sv
// Sequence per accepted request: shift-add-3 conversion over 64 bits (64-bit decimal), 32 bits
// (32-bit decimal) or none (hex), then normalise, sign, P pad characters and digits,
// where P is the pad character count (0 to 31). Result stalls hold the sequence.
// Throughput: one request at a time, at most one character per cycle from one output register.
// Reset (rst, synchronous) returns the sequencer to idle and empties the output register.
module integer_to_ascii_padded
  import itoa_pkg::*;
#(
  parameter int MAX_WIDTH = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam logic [5:0] MaxW = 6'(MAX_WIDTH);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CONV  = 6'b000010,
    S_NORM  = 6'b000100,
    S_SIGN  = 6'b001000,
    S_PAD   = 6'b010000,
    S_DIGIT = 6'b100000
  } state_t;

  state_t      state;
  logic [63:0] mag;
  logic [79:0] bcd;
  logic [5:0]  cnt;
  logic [4:0]  len;
  logic [5:0]  width;
  logic [5:0]  pad_cnt;
  logic        neg;
  logic        upper;
  logic [7:0]  padch;

  logic        accept;
  logic        slot_free;
  logic        emit;
  logic        in_neg;
  logic [63:0] in_mag;
  logic [79:0] bcd_adj;
  logic [5:0]  len_ext;

  assign accept    = item_valid && !item_stall;
  assign slot_free = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE);
  assign len_ext   = {1'b0, len};
  assign emit      = slot_free && ((state == S_SIGN && neg) ||
                                   (state == S_PAD && pad_cnt != 6'd0) ||
                                   (state == S_DIGIT));

  always_comb begin
    in_neg = 1'b0;
    in_mag = 64'b0;
    if (item.wide) begin
      in_neg = (item.kind == KIND_SDEC) && item.value[63];
      in_mag = in_neg ? (64'b0 - item.value) : item.value;
    end else begin
      in_neg = (item.kind == KIND_SDEC) && item.value[31];
      in_mag = {32'b0, in_neg ? (32'b0 - item.value[31:0]) : item.value[31:0]};
    end
  end

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            neg   <= in_neg;
            upper <= (item.kind == KIND_HEXU);
            padch <= item.zero_pad ? ChZero : ChSpace;
            width <= (item.pad_width > MaxW) ? MaxW : item.pad_width;
            len   <= 5'(NumDigits);
            if (item.kind == KIND_HEXL || item.kind == KIND_HEXU) begin
              bcd   <= {16'b0, in_mag};
              state <= S_NORM;
            end else begin
              bcd   <= 80'b0;
              mag   <= item.wide ? in_mag : {in_mag[31:0], 32'b0};
              cnt   <= item.wide ? 6'd63 : 6'd31;
              state <= S_CONV;
            end
          end
        end
        S_CONV: begin
          bcd <= {bcd_adj[78:0], mag[63]};
          mag <= {mag[62:0], 1'b0};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (len > 5'd1 && bcd[79:76] == 4'd0) begin
            bcd <= {bcd[75:0], 4'b0};
            len <= len - 5'd1;
          end else begin
            pad_cnt <= (width > len_ext) ? width - len_ext : 6'd0;
            state   <= S_SIGN;
          end
        end
        S_SIGN: begin
          if (!neg) begin
            state <= S_PAD;
          end else if (slot_free) begin
            result.char_out <= ChMinus;
            result.last     <= 1'b0;
            state           <= S_PAD;
          end
        end
        S_PAD: begin
          if (pad_cnt == 6'd0) begin
            state <= S_DIGIT;
          end else if (slot_free) begin
            result.char_out <= padch;
            result.last     <= 1'b0;
            pad_cnt         <= pad_cnt - 6'd1;
          end
        end
        S_DIGIT: begin
          if (slot_free) begin
            result.char_out <= digit_char(bcd[79:76], upper);
            result.last     <= (len == 5'd1);
            bcd             <= {bcd[75:0], 4'b0};
            len             <= len - 5'd1;
            if (len == 5'd1) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/itoa_chk.sv
// Port-level checker for the integer to ASCII block, bound to the top level.
`include "integer_to_ascii_padded_macros.svh"

module itoa_chk
  import itoa_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  `ITOA_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(result))
  `ITOA_NEXT(a_busy, item_valid && !item_stall, item_stall)
  `ITOA_IMPLY(a_mid, result_valid && !result.last, item_stall)
  `ITOA_NEXT(a_clean, item_valid && !item_stall, !result_valid || result.last)

endmodule

bind integer_to_ascii_padded itoa_chk u_itoa_chk (.*);
